// File: rtl/core/ppbd_pkg.sv
// Shared types and constants for the pen plotter bitmap drawer.
package ppbd_pkg;

  localparam int GRID_SIZE = 64;
  localparam int ROW_W     = $clog2(GRID_SIZE);
  localparam int ROW_BITS  = 64;
  localparam int COL_W     = $clog2(ROW_BITS);
  localparam int OP_W      = 3;
  localparam int DIST_W    = 13;
  localparam int POS_W     = 16;
  localparam int SUM_W     = POS_W + 1;

  localparam logic signed [SUM_W-1:0] GRID_MAX_S = SUM_W'(GRID_SIZE - 1);
  localparam logic signed [POS_W-1:0] GRID_SIZE_S = POS_W'(GRID_SIZE);
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

  typedef enum logic [OP_W-1:0] {
    OP_PEN_DOWN = 3'd0,
    OP_PEN_UP   = 3'd1,
    OP_MOVE_X   = 3'd2,
    OP_MOVE_Y   = 3'd3,
    OP_READ_ROW = 3'd4
  } ppbd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } ppbd_state_t;

endpackage

// File: rtl/core/pen_plotter_bitmap_drawer.sv
// Top level of the pen plotter: command sequencer, row memory and pen state.
//
//   channel  | ports                                          | transfer
//   ---------+------------------------------------------------+------------------------
//   command  | in_opcode, in_distance, in_row_index           | start high, busy low
//   result   | out_row_bits, out_pos_x, out_pos_y, out_pen_is_down | out_valid, one cycle
//
// Pen up/down and unused opcodes go straight to ST_DONE; read row passes ST_READ, then ST_DONE.
// Moves pass ST_SETUP, then ST_READ and ST_WRITE per row drawn (at most one row for X, up to
// GRID_SIZE rows for Y), then ST_DONE: a one-port read-modify-write of the row memory.
// busy stays high from the transfer until the result cycle; results cannot stall.
// Reset clears the pen state and the per-row valid bits.
module pen_plotter_bitmap_drawer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ppbd_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [ppbd_pkg::DIST_W-1:0]   in_distance,
  input  logic [5:0]                           in_row_index,
  output logic                                 out_valid,
  output logic [ppbd_pkg::ROW_BITS-1:0]        out_row_bits,
  output logic signed [ppbd_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [ppbd_pkg::POS_W-1:0]    out_pos_y,
  output logic                                 out_pen_is_down
);
  import ppbd_pkg::*;

  ppbd_state_t state_r, state_nxt;

  logic [OP_W-1:0]          op_r;
  logic signed [DIST_W-1:0] dist_r;
  logic [5:0]               ridx_r;

  logic signed [POS_W-1:0]  pen_col_r, pen_row_r;
  logic                     pen_lowered_r;

  logic signed [SUM_W-1:0]  end_r;
  logic [ROW_W-1:0]         cur_r, hi_r;
  logic [ROW_BITS-1:0]      mask_r;

  logic [ROW_BITS-1:0]      mem [GRID_SIZE];
  logic [GRID_SIZE-1:0]     valid_r;
  logic [ROW_BITS-1:0]      rd_data_r;
  logic                     rd_valid_r;

  logic                     out_valid_r;
  logic [ROW_BITS-1:0]      out_row_bits_r;
  logic signed [POS_W-1:0]  out_pos_x_r, out_pos_y_r;
  logic                     out_pen_r;

  logic                     accept;
  logic                     is_move;
  logic                     mem_we;
  logic [ROW_W-1:0]         rd_addr;
  logic                     done;

  // setup arithmetic
  logic signed [SUM_W-1:0]  start_s, end_s, lo_s, hi_s;
  logic                     col_in_grid, row_in_grid, span_ok, draw_nxt;
  logic [ROW_W-1:0]         lo_c, hi_c, lo_row, hi_row;
  logic [COL_W-1:0]         lo_col, hi_col;
  logic [ROW_BITS-1:0]      mask_nxt;
  logic signed [POS_W-1:0]  end_sat;
  logic                     ridx_ok;

  assign accept  = start && !busy;
  assign is_move = (op_r == OP_MOVE_X) || (op_r == OP_MOVE_Y);

  always_comb begin
    start_s = (op_r == OP_MOVE_X) ? {pen_col_r[POS_W-1], pen_col_r}
                                  : {pen_row_r[POS_W-1], pen_row_r};
    end_s   = start_s + {{(SUM_W-DIST_W){dist_r[DIST_W-1]}}, dist_r};
    if (start_s <= end_s) begin
      lo_s = start_s;
      hi_s = end_s;
    end else begin
      lo_s = end_s;
      hi_s = start_s;
    end
    span_ok = !(hi_s < 0) && !(lo_s > GRID_MAX_S);
    lo_c    = (lo_s < 0) ? '0 : lo_s[ROW_W-1:0];
    hi_c    = (hi_s > GRID_MAX_S) ? ROW_W'(GRID_SIZE - 1) : hi_s[ROW_W-1:0];
    col_in_grid = !pen_col_r[POS_W-1] && (pen_col_r < GRID_SIZE_S);
    row_in_grid = !pen_row_r[POS_W-1] && (pen_row_r < GRID_SIZE_S);
    lo_col = COL_W'(lo_c);
    hi_col = COL_W'(hi_c);
    if (op_r == OP_MOVE_X) begin
      draw_nxt = pen_lowered_r && row_in_grid && span_ok;
      lo_row   = pen_row_r[ROW_W-1:0];
      hi_row   = pen_row_r[ROW_W-1:0];
      mask_nxt = ({ROW_BITS{1'b1}} << lo_col) &
                 ({ROW_BITS{1'b1}} >> (COL_W'(ROW_BITS - 1) - hi_col));
    end else begin
      draw_nxt = pen_lowered_r && col_in_grid && span_ok;
      lo_row   = lo_c;
      hi_row   = hi_c;
      mask_nxt = ROW_BITS'(1) << pen_col_r[COL_W-1:0];
    end
  end

  always_comb begin
    if (end_r[SUM_W-1] != end_r[SUM_W-2]) begin
      end_sat = end_r[SUM_W-1] ? POS_MIN : POS_MAX;
    end else begin
      end_sat = end_r[POS_W-1:0];
    end
    ridx_ok = {1'b0, ridx_r} < 7'(GRID_SIZE);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_opcode == OP_MOVE_X) || (in_opcode == OP_MOVE_Y)) begin
            state_nxt = ST_SETUP;
          end else if (in_opcode == OP_READ_ROW) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SETUP: state_nxt = draw_nxt ? ST_READ : ST_DONE;
      ST_READ:  state_nxt = is_move ? ST_WRITE : ST_DONE;
      ST_WRITE: state_nxt = (cur_r == hi_r) ? ST_DONE : ST_READ;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_r != ST_IDLE);
    mem_we  = (state_r == ST_WRITE);
    done    = (state_r == ST_DONE);
    rd_addr = is_move ? cur_r : ridx_r[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pen_col_r     <= '0;
      pen_row_r     <= '0;
      pen_lowered_r <= 1'b0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      if (mem_we) begin
        valid_r[cur_r] <= 1'b1;
      end
      if (done) begin
        if (op_r == OP_PEN_DOWN) begin
          pen_lowered_r <= 1'b1;
        end
        if (op_r == OP_PEN_UP) begin
          pen_lowered_r <= 1'b0;
        end
        if (op_r == OP_MOVE_X) begin
          pen_col_r <= end_sat;
        end
        if (op_r == OP_MOVE_Y) begin
          pen_row_r <= end_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      dist_r <= in_distance;
      ridx_r <= in_row_index;
    end
    if (state_r == ST_SETUP) begin
      end_r  <= end_s;
      cur_r  <= lo_row;
      hi_r   <= hi_row;
      mask_r <= mask_nxt;
    end
    if (mem_we && (cur_r != hi_r)) begin
      cur_r <= cur_r + 1'b1;
    end
    if (state_r == ST_READ) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
    if (mem_we) begin
      mem[cur_r] <= (rd_valid_r ? rd_data_r : '0) | mask_r;
    end
    if (done) begin
      out_row_bits_r <= ((op_r == OP_READ_ROW) && ridx_ok && rd_valid_r) ? rd_data_r : '0;
      out_pos_x_r    <= (op_r == OP_MOVE_X) ? end_sat : pen_col_r;
      out_pos_y_r    <= (op_r == OP_MOVE_Y) ? end_sat : pen_row_r;
      out_pen_r      <= (op_r == OP_PEN_DOWN) ? 1'b1 :
                        (op_r == OP_PEN_UP) ? 1'b0 : pen_lowered_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_bits    = out_row_bits_r;
  assign out_pos_x       = out_pos_x_r;
  assign out_pos_y       = out_pos_y_r;
  assign out_pen_is_down = out_pen_r;

endmodule

// File: rtl/core/ppbd_checker.sv
// Port-level checker for the pen plotter, with its bind to the top level.
module ppbd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import ppbd_pkg::*;

  a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after command transfer");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a command in flight");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind pen_plotter_bitmap_drawer ppbd_checker u_ppbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
